[design/scdg_pkg.sv]
// Shared types and constants for the signed chamfer distance grid.
// No dependencies.
`default_nettype none
package scdg_pkg;
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FAR    = 2'd2;

    localparam logic signed [17:0] W_EDGE    = 18'sd10;
    localparam logic signed [17:0] W_DIAG    = 18'sd14;
    localparam logic [14:0]        EDGE_DIST = 15'd5;

    // which pass the datapath runs
    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_BWD  = 2'd2;

    typedef struct packed {
        logic       start;   // load pixel (col,row) for phase
        logic [1:0] phase;
    } scdg_cmd_t;

    typedef struct packed {
        logic busy;          // pixel update in flight
    } scdg_stat_t;
endpackage
`default_nettype wire

[design/scdg_datapath.sv]
// Datapath: mask and distance memories, per-pixel init and chamfer relax sequencer.
// Depends on scdg_pkg.
`default_nettype none
module scdg_datapath #(
    parameter int CW = 6,
    parameter int RW = 6,
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire scdg_pkg::scdg_cmd_t  cmd,
    output scdg_pkg::scdg_stat_t      stat,
    input  wire logic [CW-1:0]        pc,
    input  wire logic [RW-1:0]        pr,
    input  wire logic [CW:0]          w_eff,
    input  wire logic [RW:0]          h_eff,
    input  wire logic [14:0]          far_value,
    // host port
    input  wire logic                 mwe,
    input  wire logic [CW-1:0]        hc,
    input  wire logic [RW-1:0]        hr,
    input  wire logic                 hbit,
    input  wire logic                 hre,
    output logic signed [15:0]        hdata
);
    import scdg_pkg::*;
    localparam int AW = CW + RW;
    // row-major with a power-of-two row pitch, so every {row,col} address is in range
    localparam int DEPTH = 1 << AW;

    logic              mask_mem [DEPTH];
    logic signed [15:0] dist_mem [DEPTH];

    // sequencer: step 0..4 read mask neighbors, then 5 distance taps (relax passes only), then write
    logic [3:0]  step_reg;
    logic        busy_reg;
    logic [1:0]  ph_reg;
    logic        mq_reg, inside_reg, edge_reg;
    logic signed [17:0] best_reg;
    logic [3:0]  rstep_reg;        // step whose read data is in mq/dq
    logic        rvalid_reg, roff_reg;
    logic signed [15:0] dq_reg;
    logic signed [17:0] rw_reg;

    assign stat.busy = busy_reg;

    // neighbor offsets for the current step
    logic signed [2:0] dc, dr;
    logic signed [17:0] wt;
    always_comb begin
        dc = 3'sd0; dr = 3'sd0; wt = 18'sd0;
        case (step_reg)
            4'd0: begin dc = 3'sd0;  dr = 3'sd0; end
            4'd1: begin dc = 3'sd1;  dr = 3'sd0; end
            4'd2: begin dc = -3'sd1; dr = 3'sd0; end
            4'd3: begin dc = 3'sd0;  dr = 3'sd1; end
            4'd4: begin dc = 3'sd0;  dr = -3'sd1; end
            4'd5: begin dc = -3'sd1; dr = -3'sd1; wt = W_DIAG; end
            4'd6: begin dc = -3'sd1; dr = 3'sd0;  wt = W_EDGE; end
            4'd7: begin dc = 3'sd0;  dr = -3'sd1; wt = W_EDGE; end
            4'd8: begin dc = 3'sd1;  dr = -3'sd1; wt = W_DIAG; end
            4'd9: begin dc = 3'sd0;  dr = 3'sd0;  wt = 18'sd0; end
            default: ;
        endcase
        if (ph_reg == PH_BWD) begin
            dc = -dc; dr = -dr;
        end
    end

    logic signed [CW+2:0] nc;
    logic signed [RW+2:0] nr;
    logic                 noff;
    logic [AW-1:0]        naddr;
    always_comb begin
        nc = $signed({2'b00, pc}) + (CW+3)'(dc);
        nr = $signed({2'b00, pr}) + (RW+3)'(dr);
        noff = nc < 0 || nr < 0 || nc >= $signed({2'b00, w_eff})
               || nr >= $signed({2'b00, h_eff});
        naddr = {nr[RW-1:0], nc[CW-1:0]};
    end

    logic [AW-1:0] waddr;
    assign waddr = {pr, pc};

    // read/write ports
    logic dwe;
    logic signed [15:0] dwdata;
    always_ff @(posedge aclk) begin
        if (mwe) mask_mem[{hr, hc}] <= hbit;
        mq_reg <= mask_mem[naddr];
        if (dwe) dist_mem[waddr] <= dwdata;
        if (hre) dq_reg <= dist_mem[{hr, hc}];
        else     dq_reg <= dist_mem[naddr];
    end
    assign hdata = dq_reg;

    logic signed [17:0] farp, farn, fv, cand, rb, sat;
    always_comb begin
        farp = {3'b000, far_value};
        farn = -farp;
        fv = roff_reg ? (inside_reg ? farn : farp) : 18'(dq_reg);
        cand = inside_reg ? fv - rw_reg : fv + rw_reg;
        rb = best_reg;
        if (inside_reg ? cand > rb : cand < rb) rb = cand;
        sat = rb > farp ? farp : (rb < farn ? farn : rb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; step_reg <= '0; rvalid_reg <= 1'b0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1; step_reg <= '0; ph_reg <= cmd.phase;
            rvalid_reg <= 1'b0; edge_reg <= 1'b0;
        end else if (busy_reg) begin
            rvalid_reg <= step_reg <= 4'd9;
            rstep_reg <= step_reg;
            roff_reg <= noff;
            rw_reg <= wt;
            if (step_reg <= 4'd10) step_reg <= step_reg + 4'd1;
            if (rvalid_reg) begin
                if (rstep_reg == 4'd0) begin
                    inside_reg <= mq_reg;
                    best_reg <= mq_reg ? farn : farp;
                end else if (rstep_reg <= 4'd4) begin
                    if (!roff_reg && mq_reg != inside_reg) edge_reg <= 1'b1;
                end else begin
                    best_reg <= rb;
                end
            end
            // init pass ends after mask taps, relax after distance taps; edge pixels end relax early, unwritten
            if (ph_reg == PH_INIT && step_reg == 4'd6) busy_reg <= 1'b0;
            if (ph_reg != PH_INIT && step_reg == 4'd11) busy_reg <= 1'b0;
            if (ph_reg != PH_INIT && edge_reg && step_reg == 4'd6) busy_reg <= 1'b0;
        end
    end

    always_comb begin
        dwe = 1'b0;
        dwdata = sat[15:0];
        if (busy_reg && ph_reg == PH_INIT && step_reg == 4'd6) begin
            dwe = 1'b1;
            dwdata = edge_reg ? {11'd0, EDGE_DIST[4:0]} : {1'b0, far_value};
            if (inside_reg) dwdata = -dwdata;
        end else if (busy_reg && ph_reg != PH_INIT && step_reg == 4'd11 && !edge_reg) begin
            dwe = 1'b1;
        end
    end
endmodule
`default_nettype wire

[design/scdg_ctrl.sv]
// Controller: command intake, raster walk over the three passes, result register.
// Depends on scdg_pkg.
`default_nettype none
module scdg_ctrl #(
    parameter int CW = 6,
    parameter int RW = 6,
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_cmd,
    input  wire logic [5:0]          s_col,
    input  wire logic [5:0]          s_row,
    input  wire logic                s_inside_req,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_distance,
    input  wire logic [CW:0]         w_eff,
    input  wire logic [RW:0]         h_eff,
    output scdg_pkg::scdg_cmd_t      dcmd,
    input  wire scdg_pkg::scdg_stat_t dstat,
    output logic [CW-1:0]            pc,
    output logic [RW-1:0]            pr,
    output logic                     mwe,
    output logic [CW-1:0]            hc,
    output logic [RW-1:0]            hr,
    output logic                     hbit,
    output logic                     hre,
    input  wire logic signed [15:0]  hdata
);
    import scdg_pkg::*;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KICK = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;

    logic [2:0] state_reg;
    logic [1:0] ph_reg;
    logic [CW-1:0] pc_reg;
    logic [RW-1:0] pr_reg;
    logic rd_zero_reg, mv_reg, hold_reg;
    logic signed [15:0] md_reg;

    logic acc, inrange, inmem;
    assign s_ready = state_reg == ST_IDLE && !(mv_reg && !m_ready) && !hold_reg;
    assign acc = s_valid && s_ready;
    assign inrange = 32'(s_col) < 32'(w_eff) && 32'(s_row) < 32'(h_eff);
    // drop mask writes beyond the memory
    assign inmem = 32'(s_col) < MAX_WIDTH && 32'(s_row) < MAX_HEIGHT;
    assign mwe = acc && s_cmd == CMD_WRITE && inmem;
    assign hre = acc && s_cmd == CMD_READ;
    assign hc = CW'(s_col);
    assign hr = RW'(s_row);
    assign hbit = s_inside_req;
    assign pc = pc_reg;
    assign pr = pr_reg;
    assign dcmd.start = state_reg == ST_KICK;
    assign dcmd.phase = ph_reg;
    assign m_valid = mv_reg;
    assign m_distance = md_reg;

    logic last_c, last_r, first_c, first_r;
    assign last_c = {1'b0, pc_reg} == w_eff - 1'b1;
    assign last_r = {1'b0, pr_reg} == h_eff - 1'b1;
    assign first_c = pc_reg == '0;
    assign first_r = pr_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; mv_reg <= 1'b0; hold_reg <= 1'b0;
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            hold_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (hre) begin
                        rd_zero_reg <= !inrange;
                        state_reg <= ST_RD;
                    end else if (acc && s_cmd == CMD_COMPUTE) begin
                        ph_reg <= PH_INIT; pc_reg <= '0; pr_reg <= '0;
                        state_reg <= ST_KICK;
                    end
                end
                ST_RD: begin
                    mv_reg <= 1'b1;
                    md_reg <= rd_zero_reg ? 16'sd0 : hdata;
                    state_reg <= ST_IDLE;
                end
                ST_KICK: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (!dstat.busy) begin
                        state_reg <= ST_KICK;
                        if (ph_reg == PH_BWD) begin
                            if (first_c && first_r) state_reg <= ST_IDLE;
                            else if (first_c) begin
                                pc_reg <= CW'(w_eff - 1'b1); pr_reg <= pr_reg - 1'b1;
                            end else pc_reg <= pc_reg - 1'b1;
                        end else if (last_c && last_r) begin
                            // advance to next pass
                            ph_reg <= ph_reg + 2'd1;
                            if (ph_reg == PH_FWD) begin
                                pc_reg <= pc_reg; pr_reg <= pr_reg;
                            end else begin
                                pc_reg <= '0; pr_reg <= '0;
                            end
                        end else if (last_c) begin
                            pc_reg <= '0; pr_reg <= pr_reg + 1'b1;
                        end else pc_reg <= pc_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/signed_chamfer_distance_grid.sv]
// Top level of the signed chamfer distance grid: config registers, controller, datapath.
// Depends on scdg_pkg, scdg_ctrl, scdg_datapath.
//
//  channel | signals                                   | dir
//  s_      | s_valid s_ready s_cmd s_col s_row s_inside_req | in
//  m_      | m_valid m_ready m_distance                | out
//  cfg     | cfg_we cfg_index cfg_data                 | in
//
// Writes leave input open; a read blocks input while its data is fetched, and the
// result passes the memory output register, then the result register. Compute walks
// W*H pixels three times (init, forward, backward): init pixels read mask taps, relax
// pixels also distance taps via the single read port, edge ones only mask taps. Input
// stalls during compute and while a result waits. No clearing pass after reset.
`default_nettype none
module signed_chamfer_distance_grid #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic [5:0]         s_col,
    input  wire logic [5:0]         s_row,
    input  wire logic               s_inside_req,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_distance,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [14:0]        cfg_data
);
    import scdg_pkg::*;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [6:0]  gw_reg, gh_reg;
    logic [14:0] far_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= 7'd64; gh_reg <= 7'd64; far_reg <= 15'd30000;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:  gw_reg <= cfg_data[6:0];
                REG_HEIGHT: gh_reg <= cfg_data[6:0];
                REG_FAR:    far_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW:0] w_eff;
    logic [RW:0] h_eff;
    always_comb begin
        if (gw_reg == '0) w_eff = (CW+1)'(1);
        else if (32'(gw_reg) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
        else w_eff = (CW+1)'(gw_reg);
        if (gh_reg == '0) h_eff = (RW+1)'(1);
        else if (32'(gh_reg) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
        else h_eff = (RW+1)'(gh_reg);
    end

    scdg_cmd_t dcmd;
    scdg_stat_t dstat;
    logic [CW-1:0] pc, hc;
    logic [RW-1:0] pr, hr;
    logic mwe, hbit, hre;
    logic signed [15:0] hdata;

    scdg_ctrl #(.CW(CW), .RW(RW), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_col, .s_row, .s_inside_req,
        .m_valid, .m_ready, .m_distance, .w_eff, .h_eff, .dcmd, .dstat,
        .pc, .pr, .mwe, .hc, .hr, .hbit, .hre, .hdata
    );

    scdg_datapath #(.CW(CW), .RW(RW), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .aclk, .aresetn, .cmd(dcmd), .stat(dstat), .pc, .pr, .w_eff, .h_eff,
        .far_value(far_reg), .mwe, .hc, .hr, .hbit, .hre, .hdata
    );
endmodule
`default_nettype wire
